[hw/rtl/string_table_prefix_match_core_macros.svh]
// ------------------------------------------------------------------------
// string_table_prefix_match_core assertion macros
// Shared concurrent assertion forms for the prefix match core.
// ------------------------------------------------------------------------
`ifndef STRING_TABLE_PREFIX_MATCH_CORE_MACROS_SVH
`define STRING_TABLE_PREFIX_MATCH_CORE_MACROS_SVH

// same-cycle implication
`define STPM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stpm check failed");

// next-cycle implication
`define STPM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stpm check failed");

`endif

[hw/rtl/stpm_pkg.sv]
// ------------------------------------------------------------------------
// stpm_pkg
// Types, widths and codes shared by the prefix match core.
// ------------------------------------------------------------------------
`default_nettype none

package stpm_pkg;

   localparam int DEF_NUM_SLOTS = 16;
   localparam int DEF_MAX_LEN   = 16;

   localparam int KIND_W = 2;
   localparam int SLOT_W = 4;
   localparam int POS_W  = 4;
   localparam int CHAR_W = 8;
   localparam int LEN_W  = 5;
   localparam int IDX_W  = 4;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE_BYTE  = 2'd0,
      KIND_SET_LENGTH  = 2'd1,
      KIND_SEARCH_CHAR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_WRITE_BYTE,
      OP_SET_LENGTH,
      OP_SEARCH
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [SLOT_W-1:0]  slot;
      logic [POS_W-1:0]   position;
      logic [CHAR_W-1:0]  char_value;
      logic [LEN_W-1:0]   slot_length;
      logic               last;
   } op_item_type;

   typedef struct packed {
      logic        push;
      op_item_type item;
   } q_push_type;

   typedef struct packed {
      logic        not_empty;
      logic        full;
      op_item_type head;
   } q_status_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_CMP,
      B_PICK
   } back_state_type;

endpackage

`default_nettype wire

[hw/rtl/stpm_req_if.sv]
// ------------------------------------------------------------------------
// stpm_req_if
// Request channel: table writes and search characters.
// ------------------------------------------------------------------------
`default_nettype none

interface stpm_req_if;
   import stpm_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SLOT_W-1:0] slot;
   logic [POS_W-1:0]  position;
   logic [CHAR_W-1:0] char_value;
   logic [LEN_W-1:0]  slot_length;
   logic              last;

   modport source (output valid, kind, slot, position, char_value, slot_length, last,
                   input ready);
   modport sink   (input valid, kind, slot, position, char_value, slot_length, last,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/stpm_rsp_if.sv]
// ------------------------------------------------------------------------
// stpm_rsp_if
// Response channel: one match result per completed search.
// ------------------------------------------------------------------------
`default_nettype none

interface stpm_rsp_if;
   import stpm_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [IDX_W-1:0] match_index;
   logic [LEN_W-1:0] matched_chars;

   modport source (output valid, found, match_index, matched_chars, input ready);
   modport sink   (input valid, found, match_index, matched_chars, output ready);
endinterface

`default_nettype wire

[hw/rtl/stpm_front.sv]
// ------------------------------------------------------------------------
// stpm_front
// Accepts request items, drops meaningless ones, clamps lengths.
// ------------------------------------------------------------------------
`default_nettype none

module stpm_front #(
   parameter int NUM_SLOTS = stpm_pkg::DEF_NUM_SLOTS,
   parameter int MAX_LEN   = stpm_pkg::DEF_MAX_LEN
) (
   stpm_req_if.sink                  req_ch,
   input  stpm_pkg::q_status_type    q_status,
   output stpm_pkg::q_push_type      q_push
);
   import stpm_pkg::*;

   logic        keep;
   op_item_type item;
   logic        slot_ok;
   logic        pos_ok;

   assign req_ch.ready = !q_status.full;

   assign slot_ok = int'(req_ch.slot) < NUM_SLOTS;
   assign pos_ok  = int'(req_ch.position) < MAX_LEN;

   always_comb begin
      item.op          = OP_SEARCH;
      item.slot        = req_ch.slot;
      item.position    = req_ch.position;
      item.char_value  = req_ch.char_value;
      item.last        = req_ch.last;
      item.slot_length = req_ch.slot_length;
      keep             = 1'b0;
      unique case (req_ch.kind)
         KIND_WRITE_BYTE: begin
            item.op = OP_WRITE_BYTE;
            keep    = slot_ok && pos_ok;
         end
         KIND_SET_LENGTH: begin
            item.op = OP_SET_LENGTH;
            keep    = slot_ok;
            if (int'(req_ch.slot_length) > MAX_LEN)
               item.slot_length = LEN_W'(MAX_LEN);
         end
         KIND_SEARCH_CHAR: begin
            item.op = OP_SEARCH;
            keep    = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign q_push.push = req_ch.valid && req_ch.ready && keep;
   assign q_push.item = item;

endmodule

`default_nettype wire

[hw/rtl/stpm_queue.sv]
// ------------------------------------------------------------------------
// stpm_queue
// Two-entry item queue between front and back.
// ------------------------------------------------------------------------
`default_nettype none

module stpm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  stpm_pkg::q_push_type    q_push,
   input  logic                    pop,
   output stpm_pkg::q_status_type  q_status
);
   import stpm_pkg::*;

   op_item_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_pop;

   assign do_pop = pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (q_push.push) wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      if (do_pop)      rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      if (q_push.push && !do_pop)      cnt_in = cnt_ff + QCNT_W'(1);
      else if (!q_push.push && do_pop) cnt_in = cnt_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push)
         entry_ff[wr_ptr_ff] <= q_push.item;
   end

   assign q_status.not_empty = cnt_ff != '0;
   assign q_status.full      = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.head      = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hw/rtl/stpm_back.sv]
// ------------------------------------------------------------------------
// stpm_back
// Slot table, per-slot match tracking and result selection.
// ------------------------------------------------------------------------
`default_nettype none
`include "string_table_prefix_match_core_macros.svh"

module stpm_back #(
   parameter int NUM_SLOTS = stpm_pkg::DEF_NUM_SLOTS,
   parameter int MAX_LEN   = stpm_pkg::DEF_MAX_LEN
) (
   input  logic                    clock,
   input  logic                    reset,
   input  stpm_pkg::q_status_type  q_status,
   output logic                    pop,
   stpm_rsp_if.source              rsp_ch
);
   import stpm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);
   localparam int SIDX_W = $clog2(NUM_SLOTS);

   back_state_type       state_ff, state_in;

   logic [CHAR_W-1:0]    mem_ff [NUM_SLOTS][MAX_LEN];
   logic [CHAR_W-1:0]    rd_byte_ff [NUM_SLOTS];
   logic [LEN_W-1:0]     len_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] alive_ff, alive_in;
   logic [NUM_SLOTS-1:0] qual_ff, qual_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CHAR_W-1:0]    cur_char_ff;
   logic                 cur_last_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [LEN_W-1:0]     rsp_len_ff, rsp_len_in;

   logic                 out_free;
   logic                 wr_byte, wr_len, search_start, cmp_en, pick;
   logic [ADDR_W-1:0]    rd_addr;
   logic [NUM_SLOTS-1:0] mismatch;
   logic [NUM_SLOTS-1:0] low_bit;
   logic                 count_room;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:
            if (q_status.not_empty && q_status.head.op == OP_SEARCH) state_in = B_CMP;
         B_CMP:
            state_in = cur_last_ff ? B_PICK : B_IDLE;
         B_PICK:
            if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // controls
   always_comb begin
      pop          = 1'b0;
      wr_byte      = 1'b0;
      wr_len       = 1'b0;
      search_start = 1'b0;
      cmp_en       = 1'b0;
      pick         = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            pop          = q_status.not_empty;
            wr_byte      = q_status.not_empty && q_status.head.op == OP_WRITE_BYTE;
            wr_len       = q_status.not_empty && q_status.head.op == OP_SET_LENGTH;
            search_start = q_status.not_empty && q_status.head.op == OP_SEARCH;
         end
         B_CMP:  cmp_en = 1'b1;
         B_PICK: pick   = out_free;
         default: pop   = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_IDLE;
      else       state_ff <= state_in;
   end

   assign count_room = count_ff < CNT_W'(MAX_LEN);
   // the saturated count would index past the row
   assign rd_addr    = count_room ? count_ff[ADDR_W-1:0] : '0;

   // byte table, one row per slot, all rows read at the current position
   always_ff @(posedge clock) begin
      if (wr_byte)
         mem_ff[SIDX_W'(q_status.head.slot)][ADDR_W'(q_status.head.position)] <=
            q_status.head.char_value;
      if (search_start) begin
         for (int i = 0; i < NUM_SLOTS; i++)
            rd_byte_ff[i] <= mem_ff[i][rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) len_ff[i] <= '0;
      end else if (wr_len) begin
         len_ff[SIDX_W'(q_status.head.slot)] <= q_status.head.slot_length;
      end
   end

   always_ff @(posedge clock) begin
      if (search_start) begin
         cur_char_ff <= q_status.head.char_value;
         cur_last_ff <= q_status.head.last;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++)
         mismatch[i] = count_room && (count_ff < len_ff[i]) && (rd_byte_ff[i] != cur_char_ff);
      alive_in = alive_ff;
      count_in = count_ff;
      if (cmp_en) begin
         alive_in = alive_ff & ~mismatch;
         if (count_room) count_in = count_ff + CNT_W'(1);
      end else if (pick) begin
         alive_in = {NUM_SLOTS{1'b1}};
         count_in = '0;
      end
      for (int i = 0; i < NUM_SLOTS; i++)
         qual_in[i] = alive_in[i] && (len_ff[i] != '0) && (len_ff[i] <= count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= {NUM_SLOTS{1'b1}};
         count_ff <= '0;
      end else begin
         alive_ff <= alive_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_en) qual_ff <= qual_in;
   end

   // lowest qualified slot: isolate lowest set bit, then OR-select
   assign low_bit = qual_ff & (~qual_ff + NUM_SLOTS'(1));

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_len_in   = rsp_len_ff;
      if (pick) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = |qual_ff;
         rsp_idx_in   = '0;
         rsp_len_in   = '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (low_bit[i]) begin
               rsp_idx_in = rsp_idx_in | IDX_W'(i);
               rsp_len_in = rsp_len_in | len_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_found_ff <= rsp_found_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.found         = rsp_found_ff;
   assign rsp_ch.match_index   = rsp_idx_ff;
   assign rsp_ch.matched_chars = rsp_len_ff;

   `STPM_ASSERT_IMP(a_pick_counted, clock, reset, state_ff == B_PICK, count_ff != '0)
   `STPM_ASSERT_NXT(a_rearm, clock, reset, pick, (alive_ff == {NUM_SLOTS{1'b1}}) && (count_ff == '0))
   `STPM_ASSERT_IMP(a_found_len, clock, reset, rsp_valid_ff && rsp_found_ff, rsp_len_ff != '0)
   `STPM_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, (rsp_idx_ff == '0) && (rsp_len_ff == '0))
   `STPM_ASSERT_IMP(a_count_sat, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_LEN))

endmodule

`default_nettype wire

[hw/rtl/string_table_prefix_match_core.sv]
// ------------------------------------------------------------------------
// string_table_prefix_match_core
// A table of NUM_SLOTS strings searched by streamed characters: on the last
// character the lowest non-empty slot whose string is a prefix of the search
// string is reported. The front takes one item per cycle while its two-entry
// queue has room; the back applies a byte or length write in its idle state,
// handles a search character in two steps (registered read of every slot row
// at the current position, then the per-slot compare) and on a last character
// goes on to a pick state to choose the lowest matching slot and load the
// result register once it is free; the result waits there until taken. The
// back takes a new search character only after the compare of the last one.
// ------------------------------------------------------------------------
`default_nettype none

module string_table_prefix_match_core #(
   parameter int NUM_SLOTS = stpm_pkg::DEF_NUM_SLOTS,
   parameter int MAX_LEN   = stpm_pkg::DEF_MAX_LEN
) (
   input  logic        clock,
   input  logic        reset,
   stpm_req_if.sink    req_ch,
   stpm_rsp_if.source  rsp_ch
);
   import stpm_pkg::*;

   q_push_type   q_push;
   q_status_type q_status;
   logic         pop;

   stpm_front #(
      .NUM_SLOTS (NUM_SLOTS),
      .MAX_LEN   (MAX_LEN)
   ) u_front (
      .req_ch   (req_ch),
      .q_status (q_status),
      .q_push   (q_push)
   );

   stpm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (pop),
      .q_status (q_status)
   );

   stpm_back #(
      .NUM_SLOTS (NUM_SLOTS),
      .MAX_LEN   (MAX_LEN)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire
